// ===== src/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath types for the text console writer.
package tcw_pkg;

  localparam int FUNC_W      = 2;
  localparam int CHAR_W      = 8;
  localparam int DIR_W       = 2;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 7;
  localparam int COLOR_W     = 8;
  localparam int POS_W       = 11;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  localparam logic [CHAR_W-1:0]  BLANK     = 8'h20;
  localparam logic [CHAR_W-1:0]  NEWLINE   = 8'h0A;
  localparam logic [COLOR_W-1:0] COLOR_RST = 8'd7;

  localparam logic [CFG_ADDR_W-3:0] REG_TEXT_COLOR = '0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUT  = 2'd0,
    FN_BS   = 2'd1,
    FN_MOVE = 2'd2,
    FN_NONE = 2'd3
  } tcw_func_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_UP    = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_DOWN  = 2'd2,
    DIR_LEFT  = 2'd3
  } tcw_dir_t;

  typedef struct packed {
    logic accept;
    logic clear_step;
    logic exec;
    logic scan_step;
    logic load_out;
  } tcw_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic need_scan;
    logic scan_done;
    logic out_free;
  } tcw_sts_t;

endpackage

// ===== src/tcw_if.sv =====
// Request and result channel interfaces of the text console writer.
interface tcw_in_if;
  import tcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [CHAR_W-1:0] char_code;
  logic [DIR_W-1:0]  direction;
  modport source(output valid, func, char_code, direction, input ready);
  modport sink(input valid, func, char_code, direction, output ready);
endinterface

interface tcw_out_if;
  import tcw_pkg::*;
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ROW_W-1:0]   write_row;
  logic [COL_W-1:0]   write_column;
  logic [CHAR_W-1:0]  write_char;
  logic [COLOR_W-1:0] write_color;
  logic [POS_W-1:0]   cursor_position;
  modport source(output valid, write_enable, write_row, write_column, write_char,
                 write_color, cursor_position, input ready);
  modport sink(input valid, write_enable, write_row, write_column, write_char,
               write_color, cursor_position, output ready);
endinterface

// ===== src/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/tcw_ctrl.sv =====
// Controller state machine: clearing pass, request intake, execute, row scan, result hand-off.
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output tcw_pkg::tcw_cmd_t cmd,
  input  tcw_pkg::tcw_sts_t sts
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/tcw_dp.sv =====
// Datapath: cursor registers, character store, backspace row scan and result register.
module tcw_dp #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::tcw_cmd_t             cmd,
  output tcw_pkg::tcw_sts_t             sts,
  input  logic [tcw_pkg::FUNC_W-1:0]    in_func,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::DIR_W-1:0]     in_direction,
  input  logic [tcw_pkg::COLOR_W-1:0]   text_color,
  tcw_out_if.source                     out_if
);
  import tcw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  function automatic logic [AW-1:0] lin(logic [RW-1:0] r, logic [CW-1:0] c);
    return AW'(r * COLUMNS) + AW'(c);
  endfunction

  tcw_func_t         func_r;
  logic [CHAR_W-1:0] char_r;
  tcw_dir_t          dir_r;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [AW-1:0] clr_idx_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_vld_r, rd_vld_nxt;

  logic              res_we_r, res_we_nxt;
  logic [RW-1:0]     res_row_r, res_row_nxt;
  logic [CW-1:0]     res_col_r, res_col_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;

  logic               out_vld_r;
  logic               out_we_r;
  logic [ROW_W-1:0]   out_row_r;
  logic [COL_W-1:0]   out_col_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic [COLOR_W-1:0] out_color_r;
  logic [POS_W-1:0]   out_pos_r;

  logic              wr_en;
  logic [CW-1:0]     wr_col;
  logic [CHAR_W-1:0] wr_char;
  logic              found;
  logic              need_scan;
  logic              row_last;
  logic              col_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  assign row_last = (row_r == RW'(ROWS - 1));
  assign col_last = (col_r == CW'(COLUMNS - 1));
  assign found    = rd_vld_r && (ram_rdata > BLANK);

  always_comb begin
    row_nxt      = row_r;
    col_nxt      = col_r;
    idx_nxt      = idx_r;
    rd_idx_nxt   = rd_idx_r;
    rd_vld_nxt   = rd_vld_r;
    res_we_nxt   = res_we_r;
    res_row_nxt  = res_row_r;
    res_col_nxt  = res_col_r;
    res_char_nxt = res_char_r;
    wr_en        = 1'b0;
    wr_col       = col_r;
    wr_char      = BLANK;
    need_scan    = 1'b0;
    if (cmd.exec) begin
      res_we_nxt   = 1'b0;
      res_row_nxt  = '0;
      res_col_nxt  = '0;
      res_char_nxt = '0;
      case (func_r)
        FN_PUT: begin
          if (char_r == NEWLINE) begin
            col_nxt = '0;
            row_nxt = row_last ? '0 : row_r + 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_char = char_r;
            if (col_last) begin
              col_nxt = '0;
              row_nxt = row_last ? '0 : row_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end
        end
        FN_BS: begin
          if (col_r != '0) begin
            col_nxt = col_r - 1'b1;
            wr_en   = 1'b1;
            wr_col  = col_r - 1'b1;
          end else if (row_r != '0) begin
            row_nxt    = row_r - 1'b1;
            idx_nxt    = CW'(COLUMNS - 1);
            rd_vld_nxt = 1'b0;
            need_scan  = 1'b1;
          end
        end
        FN_MOVE: begin
          case (dir_r)
            DIR_UP: begin
              if (row_r != '0) begin
                row_nxt = row_r - 1'b1;
              end
            end
            DIR_RIGHT: begin
              if (!col_last) begin
                col_nxt = col_r + 1'b1;
              end
            end
            DIR_DOWN: begin
              if (!row_last) begin
                row_nxt = row_r + 1'b1;
              end
            end
            DIR_LEFT: begin
              if (col_r != '0) begin
                col_nxt = col_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end else if (cmd.scan_step) begin
      if (found) begin
        if (rd_idx_r == CW'(COLUMNS - 1)) begin
          col_nxt = rd_idx_r;
        end else begin
          col_nxt = rd_idx_r + 1'b1;
          wr_en   = 1'b1;
          wr_col  = rd_idx_r + 1'b1;
        end
      end else if (idx_r != '0) begin
        rd_idx_nxt = idx_r;
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r - 1'b1;
      end else begin
        col_nxt = '0;
        wr_en   = 1'b1;
        wr_col  = '0;
      end
    end
    if (wr_en) begin
      res_we_nxt   = 1'b1;
      res_row_nxt  = row_r;
      res_col_nxt  = wr_col;
      res_char_nxt = wr_char;
    end
  end

  assign sts.clear_last = (clr_idx_r == AW'(CELLS - 1));
  assign sts.need_scan  = need_scan;
  assign sts.scan_done  = found || (idx_r == '0);
  assign sts.out_free   = !out_vld_r || out_if.ready;

  assign ram_we    = cmd.clear_step || wr_en;
  assign ram_waddr = cmd.clear_step ? clr_idx_r : lin(row_r, wr_col);
  assign ram_wdata = cmd.clear_step ? BLANK : wr_char;
  assign ram_raddr = lin(row_r, idx_r);

  tcw_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r     <= '0;
      col_r     <= '0;
      clr_idx_r <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      rd_vld_r <= rd_vld_nxt;
      if (cmd.clear_step) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd.load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_we_r   <= res_we_nxt;
    res_row_r  <= res_row_nxt;
    res_col_r  <= res_col_nxt;
    res_char_r <= res_char_nxt;
    if (cmd.accept) begin
      func_r <= tcw_func_t'(in_func);
      char_r <= in_char_code;
      dir_r  <= tcw_dir_t'(in_direction);
    end
    if (cmd.load_out) begin
      out_we_r    <= res_we_r;
      out_row_r   <= ROW_W'(res_row_r);
      out_col_r   <= COL_W'(res_col_r);
      out_char_r  <= res_char_r;
      out_color_r <= res_we_r ? text_color : '0;
      out_pos_r   <= POS_W'(lin(row_r, col_r));
    end
  end

  assign out_if.valid           = out_vld_r;
  assign out_if.write_enable    = out_we_r;
  assign out_if.write_row       = out_row_r;
  assign out_if.write_column    = out_col_r;
  assign out_if.write_char      = out_char_r;
  assign out_if.write_color     = out_color_r;
  assign out_if.cursor_position = out_pos_r;

endmodule

// ===== src/text_console_cursor_writer_core.sv =====
// Top level of the text console cursor writer: channels, register port, controller, datapath.
//
// Requests enter on in_if (func, char_code, direction) with a valid/ready handshake.
// Each request yields exactly one result on out_if: the cell written (if any) with its
// character and attribute byte, and the linear cursor position after the request.
// Each accepted request goes through the execute state, the row scan where needed, and the
// done state, whose result is loaded into the output register once that is free; the next
// request is accepted only after that load. A backspace at the start of any row but the
// first scans the row above through the character store read port, one column per cycle.
// The result sits in an output register; a stalled receiver holds it there while the
// next request is already taken and worked on, and the block stops accepting only when
// a second result is ready and the register is still full.
// After reset the character store is swept to blanks, one cell per cycle; no request is
// accepted during the sweep, while register writes are taken as usual. The cursor resets
// to the origin and text_color to 7. text_color sits at byte address 0 of the cfg_ port and
// is to be written only while idle; the user is bound by this, the block does not enforce it.
module text_console_cursor_writer_core #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tcw_in_if.sink                          in_if,
  tcw_out_if.source                       out_if,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tcw_pkg::*;

  logic [COLOR_W-1:0] color_r;
  logic               cfg_sel_color;
  tcw_cmd_t           cmd;
  tcw_sts_t           sts;

  assign cfg_pready    = 1'b1;
  assign cfg_sel_color = (cfg_paddr[CFG_ADDR_W-1:2] == REG_TEXT_COLOR);
  assign cfg_prdata    = cfg_sel_color ? CFG_DATA_W'(color_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= COLOR_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_color) begin
      color_r <= cfg_pwdata[COLOR_W-1:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_if.valid),
    .in_ready(in_if.ready),
    .cmd     (cmd),
    .sts     (sts)
  );

  tcw_dp #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_func     (in_if.func),
    .in_char_code(in_if.char_code),
    .in_direction(in_if.direction),
    .text_color  (color_r),
    .out_if      (out_if)
  );

endmodule

// ===== sim/tb.sv =====
// Testbench for the text console cursor writer: directed and random requests checked on the fly.
`timescale 1ns / 100ps

module tb;
  import tcw_pkg::*;

  localparam int N_COLS     = COLUMNS_DEF;
  localparam int N_ROWS     = ROWS_DEF;
  localparam int N_CELLS    = N_COLS * N_ROWS;
  localparam int ITEM_GOAL  = 1600;
  localparam int QUIET_MAX  = 20000;
  localparam logic [CFG_ADDR_W-1:0] COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

  typedef struct packed {
    logic               we;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [CHAR_W-1:0]  chr;
    logic [COLOR_W-1:0] color;
    logic [POS_W-1:0]   pos;
  } cell_update_t;

  logic clk;
  logic rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  tcw_in_if  req_ch ();
  tcw_out_if res_ch ();

  text_console_cursor_writer_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (req_ch),
    .out_if      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [CHAR_W-1:0]  screen [0:N_CELLS-1];
  int                 cur_row;
  int                 cur_col;
  logic [COLOR_W-1:0] cur_color;
  cell_update_t       pending_updates [$];

  int fails;
  int sent;
  int quiet_cycles;
  int sink_hold;
  bit src_idle;
  bit snk_idle;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cell_update_t console_apply(input tcw_func_t f, input logic [CHAR_W-1:0] ch,
                                                 input tcw_dir_t d);
    cell_update_t u;
    int i;
    int hit;
    bit found;
    u = '0;
    found = 1'b0;
    hit = 0;
    case (f)
      FN_PUT: begin
        if (ch == NEWLINE) begin
          cur_row = (cur_row + 1) % N_ROWS;
          cur_col = 0;
        end else begin
          u.we  = 1'b1;
          u.row = ROW_W'(cur_row);
          u.col = COL_W'(cur_col);
          u.chr = ch;
          screen[cur_row * N_COLS + cur_col] = ch;
          cur_col++;
          if (cur_col >= N_COLS) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= N_ROWS) cur_row = 0;
          end
        end
      end
      FN_BS: begin
        if (cur_col != 0) begin
          cur_col--;
          u.we = 1'b1;
        end else if (cur_row != 0) begin
          cur_row--;
          u.we = 1'b1;
          for (i = N_COLS - 1; i > 0 && !found; i--) begin
            if (screen[cur_row * N_COLS + i] > BLANK) begin
              found = 1'b1;
              hit = i;
            end
          end
          if (found) begin
            if (hit == N_COLS - 1) begin
              cur_col = hit;
              u.we = 1'b0;
            end else begin
              cur_col = hit + 1;
            end
          end
        end
        if (u.we) begin
          u.row = ROW_W'(cur_row);
          u.col = COL_W'(cur_col);
          u.chr = BLANK;
          screen[cur_row * N_COLS + cur_col] = BLANK;
        end
      end
      FN_MOVE: begin
        case (d)
          DIR_UP:    if (cur_row != 0) cur_row--;
          DIR_RIGHT: if (cur_col + 1 < N_COLS) cur_col++;
          DIR_DOWN:  if (cur_row + 1 < N_ROWS) cur_row++;
          default:   if (cur_col != 0) cur_col--;
        endcase
      end
      default: ;
    endcase
    if (u.we) u.color = cur_color;
    u.pos = POS_W'(cur_row * N_COLS + cur_col);
    return u;
  endfunction

  function automatic logic [CHAR_W-1:0] any_byte();
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return CHAR_W'($urandom_range(8'h21, 8'h7E));
    if (r == 7) return NEWLINE;
    if (r == 8) return BLANK;
    return any_byte();
  endfunction

  function automatic tcw_dir_t any_dir();
    return tcw_dir_t'($urandom_range(0, 3));
  endfunction

  task automatic send_req(input tcw_func_t f, input logic [CHAR_W-1:0] ch, input tcw_dir_t d);
    int gap;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.func      <= f;
    req_ch.char_code <= ch;
    req_ch.direction <= d;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    pending_updates.push_back(console_apply(f, ch, d));
    if (f != FN_NONE) sent++;
  endtask

  task automatic put_char(input logic [CHAR_W-1:0] ch);
    send_req(FN_PUT, ch, any_dir());
  endtask

  task automatic backspace();
    send_req(FN_BS, any_byte(), any_dir());
  endtask

  task automatic nudge_cursor(input tcw_dir_t d);
    send_req(FN_MOVE, any_byte(), d);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_updates.size() != 0);
  endtask

  task automatic write_color(input logic [COLOR_W-1:0] c);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= COLOR_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(c);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_color = c;
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cell_update_t want;
    if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_updates.size() == 0) begin
        $error("result with no request pending");
        fails++;
      end else begin
        want = pending_updates.pop_front();
        check_field("write_enable", 16'(want.we), 16'(res_ch.write_enable));
        check_field("write_row", 16'(want.row), 16'(res_ch.write_row));
        check_field("write_column", 16'(want.col), 16'(res_ch.write_column));
        check_field("write_char", 16'(want.chr), 16'(res_ch.write_char));
        check_field("write_color", 16'(want.color), 16'(res_ch.write_color));
        check_field("cursor_position", 16'(want.pos), 16'(res_ch.cursor_position));
      end
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_MAX) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int n;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold > 0) begin
        n = sink_hold;
        sink_hold = 0;
      end else begin
        n = snk_idle ? $urandom_range(0, 15) : 0;
      end
      if (n > 0) begin
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
    end
  end

  task automatic test_origin_and_edges();
    backspace();
    nudge_cursor(DIR_UP);
    nudge_cursor(DIR_LEFT);
    send_req(FN_NONE, 8'hFF, DIR_LEFT);
    nudge_cursor(DIR_RIGHT);
    nudge_cursor(DIR_DOWN);
    nudge_cursor(DIR_UP);
    nudge_cursor(DIR_LEFT);
  endtask

  task automatic test_put_and_backspace();
    put_char(8'h41);
    backspace();
    put_char(8'h00);
    put_char(8'hFF);
    put_char(BLANK);
    put_char(NEWLINE);
    backspace();
    put_char(NEWLINE);
    put_char(NEWLINE);
    backspace();
  endtask

  task automatic test_colors();
    drain();
    write_color(8'h00);
    repeat (6) put_char(text_byte());
    backspace();
    drain();
    write_color(8'hFF);
    repeat (6) put_char(text_byte());
    backspace();
    drain();
    write_color(COLOR_W'($urandom_range(0, 255)));
  endtask

  task automatic test_backpressure();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    sink_hold = 300;
    repeat (40) put_char(text_byte());
    drain();
  endtask

  task automatic random_sequence();
    int kind;
    int len;
    tcw_dir_t d;
    kind = $urandom_range(0, 99);
    if (kind < 35) begin
      len = $urandom_range(1, 30);
      repeat (len) put_char(text_byte());
    end else if (kind < 55) begin
      if ($urandom_range(0, 1)) put_char(NEWLINE);
      len = $urandom_range(1, 12);
      repeat (len) backspace();
    end else if (kind < 70) begin
      len = $urandom_range(1, 8);
      repeat (len) nudge_cursor(any_dir());
    end else if (kind < 77) begin
      d = any_dir();
      len = $urandom_range(20, 90);
      repeat (len) nudge_cursor(d);
    end else if (kind < 85) begin
      while (cur_col != N_COLS - 1) put_char(CHAR_W'($urandom_range(8'h21, 8'hFF)));
      put_char($urandom_range(0, 3) == 0 ? any_byte() : CHAR_W'($urandom_range(8'h21, 8'h7E)));
      len = $urandom_range(1, 3);
      repeat (len) backspace();
    end else if (kind < 90) begin
      while (cur_row != N_ROWS - 1) nudge_cursor(DIR_DOWN);
      while (cur_col != N_COLS - 1) nudge_cursor(DIR_RIGHT);
      put_char(text_byte());
    end else begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        if ($urandom_range(0, 1)) send_req(FN_NONE, any_byte(), any_dir());
        else send_req(tcw_func_t'($urandom_range(0, 3)), any_byte(), any_dir());
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    int phase_end;
    int pick;
    phase = 0;
    while (sent < ITEM_GOAL) begin
      if (phase == 0) begin
        src_idle = 1'b0;
        snk_idle = 1'b0;
      end else begin
        src_idle = $urandom_range(0, 1);
        snk_idle = $urandom_range(0, 1);
      end
      phase_end = sent + 200;
      while (sent < phase_end) random_sequence();
      drain();
      pick = $urandom_range(0, 3);
      if (pick == 0) write_color(8'h00);
      else if (pick == 1) write_color(8'hFF);
      else write_color(COLOR_W'($urandom_range(0, 255)));
      phase++;
    end
  endtask

  initial begin
    int i;
    fails = 0;
    sent = 0;
    quiet_cycles = 0;
    sink_hold = 0;
    src_idle = 1'b1;
    snk_idle = 1'b1;
    for (i = 0; i < N_CELLS; i++) screen[i] = BLANK;
    cur_row = 0;
    cur_col = 0;
    cur_color = COLOR_RST;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.func      <= FN_NONE;
    req_ch.char_code <= '0;
    req_ch.direction <= DIR_UP;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_origin_and_edges();
    test_put_and_backspace();
    test_colors();
    test_backpressure();
    test_random_traffic();

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending_updates.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
